>>> rtl/ipv6_header_chain_parser_top_assert.svh
// assertion macros for the ipv6 header chain parser
`ifndef IPV6_HEADER_CHAIN_PARSER_TOP_ASSERT_SVH
`define IPV6_HEADER_CHAIN_PARSER_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define HCP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define HCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/ihcp_pkg.sv
//------------------------------------------------------------------------------
// ihcp_pkg
// types and constants for the ipv6 header chain parser
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package ihcp_pkg;

  localparam int OFS_W = 17;

  typedef enum logic [9:0] {
    PH_FIXED    = 10'b0000000001,
    PH_EXT      = 10'b0000000010,
    PH_FRAG     = 10'b0000000100,
    PH_TCP      = 10'b0000001000,
    PH_OUT_ICMP = 10'b0000010000,
    PH_IN_FIXED = 10'b0000100000,
    PH_IN_ICMP  = 10'b0001000000,
    PH_NEED_BAD = 10'b0010000000,
    PH_DONE     = 10'b0100000000,
    PH_ERROR    = 10'b1000000000
  } phase_t;

  localparam logic [1:0] PROTO_TCP   = 2'd0;
  localparam logic [1:0] PROTO_UDP   = 2'd1;
  localparam logic [1:0] PROTO_ICMP  = 2'd2;
  localparam logic [1:0] PROTO_OTHER = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNC     = 3'd1;
  localparam logic [2:0] ST_HDR_ERR   = 3'd2;
  localparam logic [2:0] ST_FRAG_PING = 3'd3;
  localparam logic [2:0] ST_OVERRUN   = 3'd4;

  localparam logic [7:0] NH_HOP   = 8'd0;
  localparam logic [7:0] NH_TCP   = 8'd6;
  localparam logic [7:0] NH_UDP   = 8'd17;
  localparam logic [7:0] NH_ROUTE = 8'd43;
  localparam logic [7:0] NH_FRAG  = 8'd44;
  localparam logic [7:0] NH_ICMP  = 8'd58;
  localparam logic [7:0] NH_DEST  = 8'd60;

  localparam logic [7:0] ICMP_ECHO_REQ = 8'd128;
  localparam logic [7:0] ICMP_ECHO_REP = 8'd129;

  function automatic logic icmp_is_error(input logic [7:0] t);
    return (t >= 8'd1) && (t <= 8'd4);
  endfunction

  function automatic logic icmp_is_echo(input logic [7:0] t);
    return (t == ICMP_ECHO_REQ) || (t == ICMP_ECHO_REP);
  endfunction

endpackage

>>> rtl/ipv6_header_chain_parser_top.sv
// Parses an IPv6 packet arriving one byte per request on s_axis (tdata = byte,
// tlast = final byte) and walks the extension header chain. One request is
// taken every cycle; each byte is checked against the running header offset
// in a single register-to-register step. The result of a packet is loaded into
// an output register at the edge that takes its final byte and shows on m_axis
// from the next cycle. While a result waits unaccepted, s_axis_tready is low,
// so the input stalls only for as long as m_axis_tready is held off.
//------------------------------------------------------------------------------
// ipv6_header_chain_parser_top
// ipv6 next-header chain walker with layer-4 offset and sanity checks
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ipv6_header_chain_parser_top_assert.svh"

module ipv6_header_chain_parser_top
  import ihcp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 65575
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        siit_mode_we,
  input  logic        siit_mode_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], layer-4 kind[4:3], layer-4 start[21:5], data start[38:22],
  // has_fragment[39], fragment_offset[56:40], zero fill [63:57]
  output logic [63:0] m_axis_tdata
);

  localparam int CW = OFS_W;
  localparam logic [CW-1:0] MAXB = CW'(MAX_PACKET_BYTES);

  logic          siit_mode;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [15:0]   plen, plen_next;
  logic [7:0]    nh, nh_next;
  logic [CW-1:0] hs, hs_next;
  phase_t        ph, ph_next;
  logic          ff, ff_next;
  logic          fragd, fragd_next;
  logic [7:0]    icmp_t, icmp_t_next;
  logic [1:0]    r_proto, r_proto_next;
  logic [CW-1:0] r_l4, r_l4_next;
  logic [CW-1:0] r_pay, r_pay_next;
  logic          r_hf, r_hf_next;
  logic [CW-1:0] r_fo, r_fo_next;
  logic [2:0]    err, err_next;
  logic          inner, inner_next;
  logic [CW-1:0] pend, pend_next;
  logic [CW-1:0] ipay, ipay_next;
  logic [63:0]   out_data, out_data_next;
  logic          out_valid;

  logic          acc;
  logic [CW-1:0] d;
  logic [7:0]    b;
  logic [CW-1:0] len;
  logic [2:0]    st;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign b = s_axis_tdata;
  assign d = byte_count - hs;

  always_comb begin
    logic [CW-1:0] ehs;
    logic          efin;
    logic [1:0]    eproto;
    logic [CW-1:0] epay;
    logic          doenter;
    byte_count_next = byte_count;
    plen_next = plen; nh_next = nh; hs_next = hs; ph_next = ph; ff_next = ff;
    fragd_next = fragd; icmp_t_next = icmp_t; r_proto_next = r_proto;
    r_l4_next = r_l4; r_pay_next = r_pay; r_hf_next = r_hf; r_fo_next = r_fo;
    err_next = err; inner_next = inner; pend_next = pend; ipay_next = ipay;
    ehs = '0; doenter = 1'b0; efin = 1'b0; eproto = PROTO_OTHER; epay = '0;

    if (byte_count < MAXB) begin
      byte_count_next = byte_count + 1'b1;
      if (ph != PH_DONE && ph != PH_ERROR && byte_count >= hs) begin
        unique case (ph)
          PH_FIXED: begin
            if (d == CW'(4)) plen_next = {b, 8'd0};
            else if (d == CW'(5)) plen_next = {plen[15:8], b};
            else if (d == CW'(6)) nh_next = b;
            else if (d == CW'(39)) begin
              ehs = hs + CW'(40); doenter = 1'b1;
            end
          end
          PH_EXT: begin
            if (d == CW'(0)) nh_next = b;
            else if (d == CW'(1)) begin
              ehs = hs + CW'(8) + {{(CW-11){1'b0}}, b, 3'b000}; doenter = 1'b1;
            end
          end
          PH_FRAG: begin
            if (d == CW'(0)) begin
              nh_next = b;
              if (!inner) begin
                r_hf_next = 1'b1; r_fo_next = hs;
              end
            end else if (d == CW'(2)) ff_next = (b == 8'd0);
            else if (d == CW'(3)) begin
              ff_next = ff && (b[7:3] == 5'd0);
              if (!inner) fragd_next = !(ff && (b[7:3] == 5'd0)) || b[0];
            end else if (d == CW'(7)) begin
              ehs = hs + CW'(8); doenter = 1'b1;
            end
          end
          PH_TCP: begin
            if (d == CW'(12)) pend_next = hs + {{(CW-6){1'b0}}, b[7:4], 2'b00};
            else if (d == CW'(19)) begin
              efin = 1'b1; eproto = PROTO_TCP; ehs = hs; epay = pend;
            end
          end
          PH_OUT_ICMP: begin
            if (d == CW'(0)) icmp_t_next = b;
            else if (d == CW'(7)) begin
              if (!icmp_is_error(icmp_t)) ph_next = PH_DONE;
              else if (ff) begin
                inner_next = 1'b1; hs_next = hs + CW'(8); ph_next = PH_IN_FIXED;
              end else begin
                hs_next = hs + CW'(39); ph_next = PH_NEED_BAD;
              end
            end
          end
          PH_IN_FIXED: begin
            if (d == CW'(0) && b[7:4] != 4'd6) begin
              hs_next = hs + CW'(39); ph_next = PH_NEED_BAD;
            end else if (d == CW'(6)) nh_next = b;
            else if (d == CW'(39)) begin
              ehs = hs + CW'(40); doenter = 1'b1;
            end
          end
          PH_IN_ICMP: begin
            if (d == CW'(0) && icmp_is_error(b)) begin
              hs_next = hs + CW'(7); ph_next = PH_NEED_BAD;
            end else if (d == CW'(7)) ph_next = PH_DONE;
          end
          PH_NEED_BAD: begin
            if (d == CW'(0)) begin
              err_next = ST_HDR_ERR; ph_next = PH_ERROR;
            end
          end
          default: ;
        endcase
      end
    end else begin
      byte_count_next = MAXB + 1'b1;
    end

    if (doenter) begin
      hs_next = ehs;
      unique case (nh_next)
        NH_HOP, NH_ROUTE, NH_DEST: ph_next = PH_EXT;
        NH_FRAG: ph_next = PH_FRAG;
        NH_TCP: begin
          if (ff_next) ph_next = PH_TCP;
          else begin
            efin = 1'b1; eproto = PROTO_TCP; epay = ehs;
          end
        end
        NH_UDP: begin
          efin = 1'b1; eproto = PROTO_UDP; epay = ff_next ? ehs + CW'(8) : ehs;
        end
        NH_ICMP: begin
          efin = 1'b1; eproto = PROTO_ICMP; epay = ff_next ? ehs + CW'(8) : ehs;
        end
        default: begin
          efin = 1'b1; eproto = PROTO_OTHER; epay = ehs;
        end
      endcase
    end

    if (efin) begin
      if (!inner) begin
        r_proto_next = eproto; r_l4_next = ehs; r_pay_next = epay; hs_next = ehs;
        ph_next = (eproto == PROTO_ICMP) ? PH_OUT_ICMP : PH_DONE;
      end else if (!ff_next) begin
        err_next = ST_HDR_ERR; ph_next = PH_ERROR;
      end else begin
        ipay_next = epay; hs_next = ehs;
        ph_next = (eproto == PROTO_ICMP) ? PH_IN_ICMP : PH_DONE;
      end
    end
  end

  // final status uses the updated state of the last byte
  always_comb begin
    len = byte_count_next;
    if (len > MAXB || len != CW'(40) + {1'b0, plen_next}) st = ST_HDR_ERR;
    else if (ph_next == PH_ERROR) st = err_next;
    else if (ph_next != PH_DONE) st = ST_TRUNC;
    else if (ipay_next > len) st = ST_OVERRUN;
    else if (siit_mode && r_hf_next && r_proto_next == PROTO_ICMP &&
             icmp_is_echo(icmp_t_next) && fragd_next) st = ST_FRAG_PING;
    else if (r_pay_next > len) st = ST_OVERRUN;
    else st = ST_OK;
    out_data_next = '0;
    out_data_next[2:0] = st;
    if (st == ST_OK) begin
      out_data_next[4:3]   = r_proto_next;
      out_data_next[21:5]  = r_l4_next;
      out_data_next[38:22] = r_pay_next;
      out_data_next[39]    = r_hf_next;
      out_data_next[56:40] = r_hf_next ? r_fo_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      siit_mode <= 1'b0;
    end else if (siit_mode_we) begin
      siit_mode <= siit_mode_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && s_axis_tlast)) begin
      byte_count <= '0; plen <= '0; nh <= '0; hs <= '0; ph <= PH_FIXED;
      ff <= 1'b1; fragd <= 1'b0; icmp_t <= '0; r_proto <= '0; r_l4 <= '0;
      r_pay <= '0; r_hf <= 1'b0; r_fo <= '0; err <= '0; inner <= 1'b0;
      pend <= '0; ipay <= '0;
    end else if (acc) begin
      byte_count <= byte_count_next; plen <= plen_next; nh <= nh_next;
      hs <= hs_next; ph <= ph_next; ff <= ff_next; fragd <= fragd_next;
      icmp_t <= icmp_t_next; r_proto <= r_proto_next; r_l4 <= r_l4_next;
      r_pay <= r_pay_next; r_hf <= r_hf_next; r_fo <= r_fo_next;
      err <= err_next; inner <= inner_next; pend <= pend_next; ipay <= ipay_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc && s_axis_tlast) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && s_axis_tlast) begin
      out_data <= out_data_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  `HCP_ASSERT_NEXT(a_result_follows_last, acc && s_axis_tlast, m_axis_tvalid)
  `HCP_ASSERT_IMPL(a_fail_clears_fields, m_axis_tvalid && m_axis_tdata[2:0] != ST_OK,
    m_axis_tdata[63:3] == '0)
  `HCP_ASSERT_IMPL(a_ready_when_drained, !m_axis_tvalid, s_axis_tready)
  `HCP_ASSERT_IMPL(a_hs_not_past_count, ph == PH_FIXED, hs == '0)

endmodule
